// File: rtl/ase_pkg.sv
// ase_pkg: shared types and codes for the array stack engine
// command and status codes, datapath command and status structs, fsm states
// no dependencies
package ase_pkg;

   localparam int unsigned POS_W  = 5;
   localparam int unsigned WORD_W = 32;

   // command codes on req_command
   localparam logic [2:0] CMD_PUSH    = 3'd0;
   localparam logic [2:0] CMD_POP     = 3'd1;
   localparam logic [2:0] CMD_PEEP    = 3'd2;
   localparam logic [2:0] CMD_CHANGE  = 3'd3;
   localparam logic [2:0] CMD_DISPLAY = 3'd4;

   // status codes on rsp_status
   localparam logic [1:0] RSP_OK       = 2'd0;
   localparam logic [1:0] RSP_OVERFLOW = 2'd1;
   localparam logic [1:0] RSP_UNDER    = 2'd2;
   localparam logic [1:0] RSP_EMPTY    = 2'd3;

   typedef enum logic [2:0] {
      MEM_NONE,
      MEM_WR_TOP,
      MEM_RD_TOP,
      MEM_RD_POS,
      MEM_WR_POS,
      MEM_RD_DISP_FIRST,
      MEM_RD_DISP_NEXT
   } mem_op_type;

   typedef struct packed {
      mem_op_type op;
      logic       emit;
      logic [1:0] status;
      logic       last;
      logic       from_mem;
   } dp_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic one;
      logic pos_bad;
      logic ptr_zero;
   } dp_status_type;

   typedef enum logic {
      S_IDLE,
      S_DISP
   } state_type;

endpackage

// File: rtl/ase_ram.sv
// ase_ram: generic single write port, single read port ram
// registered read data, no reset on contents; no dependencies
module ase_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ase_ctrl.sv
// ase_ctrl: command decode and display sequencer for the array stack engine
// drives datapath commands from req_command and datapath status; uses ase_pkg
module ase_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [2:0]            req_command,
   input  ase_pkg::dp_status_type dp_status,
   output ase_pkg::dp_cmd_type   dp_cmd
);
   import ase_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      dp_cmd.op       = MEM_NONE;
      dp_cmd.emit     = 1'b0;
      dp_cmd.status   = RSP_OK;
      dp_cmd.last     = 1'b1;
      dp_cmd.from_mem = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_command)
                  CMD_PUSH: begin
                     dp_cmd.emit = 1'b1;
                     if (dp_status.full) begin
                        dp_cmd.status = RSP_OVERFLOW;
                     end else begin
                        dp_cmd.op = MEM_WR_TOP;
                     end
                  end
                  CMD_POP: begin
                     dp_cmd.emit = 1'b1;
                     if (dp_status.empty) begin
                        dp_cmd.status = RSP_UNDER;
                     end else begin
                        dp_cmd.op       = MEM_RD_TOP;
                        dp_cmd.from_mem = 1'b1;
                     end
                  end
                  CMD_PEEP: begin
                     dp_cmd.emit = 1'b1;
                     if (dp_status.pos_bad) begin
                        dp_cmd.status = RSP_UNDER;
                     end else begin
                        dp_cmd.op       = MEM_RD_POS;
                        dp_cmd.from_mem = 1'b1;
                     end
                  end
                  CMD_CHANGE: begin
                     dp_cmd.emit = 1'b1;
                     if (dp_status.pos_bad) begin
                        dp_cmd.status = RSP_UNDER;
                     end else begin
                        dp_cmd.op = MEM_WR_POS;
                     end
                  end
                  CMD_DISPLAY: begin
                     dp_cmd.emit = 1'b1;
                     if (dp_status.empty) begin
                        dp_cmd.status = RSP_EMPTY;
                     end else begin
                        dp_cmd.op       = MEM_RD_DISP_FIRST;
                        dp_cmd.from_mem = 1'b1;
                        dp_cmd.last     = dp_status.one;
                        if (!dp_status.one) begin
                           state_in = S_DISP;
                        end
                     end
                  end
                  default: begin
                     // unused codes are dropped with no result
                  end
               endcase
            end
         end
         S_DISP: begin
            dp_cmd.op       = MEM_RD_DISP_NEXT;
            dp_cmd.emit     = 1'b1;
            dp_cmd.from_mem = 1'b1;
            dp_cmd.last     = dp_status.ptr_zero;
            if (dp_status.ptr_zero) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// File: rtl/ase_dp.sv
// ase_dp: stack datapath, entry count, display pointer, ram and result registers
// executes ase_ctrl commands; uses ase_pkg and ase_ram
module ase_dp #(
   parameter int unsigned STACK_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [ase_pkg::WORD_W-1:0]   req_value,
   input  logic [ase_pkg::POS_W-1:0]           req_position,
   input  ase_pkg::dp_cmd_type                 dp_cmd,
   output ase_pkg::dp_status_type              dp_status,
   output logic                                rsp_valid,
   output logic signed [ase_pkg::WORD_W-1:0]   rsp_data,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_last
);
   import ase_pkg::*;

   localparam int unsigned AW   = $clog2(STACK_DEPTH);
   localparam int unsigned CW   = $clog2(STACK_DEPTH + 1);
   localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     count_in;
   logic [AW-1:0]     ptr_ff;
   logic [AW-1:0]     ptr_in;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic              rsp_last_ff;
   logic              rsp_mem_ff;

   logic [CMPW-1:0]   pos_ext;
   logic [CMPW-1:0]   cnt_ext;
   logic [CMPW-1:0]   pos_diff;
   logic [AW-1:0]     top_addr;
   logic [AW-1:0]     pos_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     rd_addr;
   logic [WORD_W-1:0] rd_data;

   assign pos_ext  = CMPW'(req_position);
   assign cnt_ext  = CMPW'(count_ff);
   assign pos_diff = cnt_ext - pos_ext;
   assign top_addr = AW'(count_ff - CW'(1));
   assign pos_addr = AW'(pos_diff);

   assign dp_status.empty    = (count_ff == '0);
   assign dp_status.full     = (count_ff == CW'(STACK_DEPTH));
   assign dp_status.one      = (count_ff == CW'(1));
   assign dp_status.pos_bad  = (req_position == '0) || (pos_ext > cnt_ext);
   assign dp_status.ptr_zero = (ptr_ff == '0);

   always_comb begin
      count_in = count_ff;
      ptr_in   = ptr_ff;
      wr_en    = 1'b0;
      wr_addr  = pos_addr;
      rd_addr  = top_addr;
      case (dp_cmd.op)
         MEM_WR_TOP: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(count_ff);
            count_in = count_ff + CW'(1);
         end
         MEM_RD_TOP: begin
            count_in = count_ff - CW'(1);
         end
         MEM_RD_POS: begin
            rd_addr = pos_addr;
         end
         MEM_WR_POS: begin
            wr_en = 1'b1;
         end
         MEM_RD_DISP_FIRST: begin
            ptr_in = top_addr - AW'(1);
         end
         MEM_RD_DISP_NEXT: begin
            rd_addr = ptr_ff;
            ptr_in  = ptr_ff - AW'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= dp_cmd.emit;
      end
      ptr_ff        <= ptr_in;
      rsp_status_ff <= dp_cmd.status;
      rsp_last_ff   <= dp_cmd.last;
      rsp_mem_ff    <= dp_cmd.from_mem;
   end

   ase_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STACK_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_mem_ff ? rd_data : '0;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("entry count above depth");

   a_overflow_full : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == RSP_OVERFLOW) |-> (count_ff == CW'(STACK_DEPTH)))
      else $error("overflow reported with room left");

   a_empty_disp : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == RSP_EMPTY) |-> (count_ff == '0 && rsp_last_ff))
      else $error("empty display with stored words");

   a_mem_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_mem_ff) |-> (rsp_status_ff == RSP_OK))
      else $error("memory word sent with error status");

   a_push_count : assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.op == MEM_WR_TOP) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("push did not bump count");

endmodule

// File: rtl/array_stack_engine.sv
// array_stack_engine: top level of a bounded lifo stack of signed 32-bit words
// joins ase_ctrl and ase_dp; uses ase_pkg
//
// usage
//   request channel: drive req_command, req_value, req_position with start high;
//   the beat is taken at a rising edge where start is high and busy is low
//   commands: push, pop, peep (read at position from top, 1 is top), change
//   (overwrite at position), display (every word top to bottom); codes 5 to 7
//   are dropped with no response
//   response channel: rsp_valid marks a beat of rsp_data, rsp_status, rsp_last
//   for exactly one cycle; the receiver cannot stall it
// latency and throughput
//   push, pop, peep and change: response in the cycle after the accept edge,
//   busy stays low, so one command per cycle; read data comes from the
//   store's registered read port
//   display: one beat per stored word on consecutive cycles, with busy high
//   until the last read is issued by the display sequencer
// reset
//   synchronous, clears the entry count and the sequencer; store contents are
//   left undefined and only words below the count are returned
module array_stack_engine #(
   parameter int unsigned STACK_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_command,
   input  logic signed [31:0] req_value,
   input  logic [4:0]         req_position,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_data,
   output logic [1:0]         rsp_status,
   output logic               rsp_last
);
   import ase_pkg::*;

   // command and status between sequencer and datapath
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // decode and display sequencer
   ase_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_command (req_command),
      .dp_status   (dp_status),
      .dp_cmd      (dp_cmd)
   );

   // count, store, pointer and response registers
   ase_dp #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_value    (req_value),
      .req_position (req_position),
      .dp_cmd       (dp_cmd),
      .dp_status    (dp_status),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last)
   );

endmodule

// File: bench/stack_shadow_pkg.sv
`timescale 1ns / 1ps
// stack_shadow_pkg: reply type and scoreboard class for the array stack engine bench
// keeps a shadow stack, predicts every reply beat and checks the ones the block sends
// depends on ase_pkg for command and status codes
package stack_shadow_pkg;
   import ase_pkg::*;

   localparam int unsigned STACK_WORDS = 16;

   typedef struct packed {
      logic signed [WORD_W-1:0] data;
      logic [1:0]               status;
      logic                     last;
   } stack_reply_type;

   class stack_shadow;
      logic signed [WORD_W-1:0] shadow_words [STACK_WORDS];
      int unsigned              shadow_count;
      stack_reply_type          awaited_replies [$];
      int unsigned              mismatches;
      int unsigned              replies_checked;
      int unsigned              cmd_seen [8];
      int unsigned              overflow_seen;
      int unsigned              under_seen;
      int unsigned              empty_seen;
      int unsigned              deepest;

      function new();
         shadow_count    = 0;
         mismatches      = 0;
         replies_checked = 0;
         overflow_seen   = 0;
         under_seen      = 0;
         empty_seen      = 0;
         deepest         = 0;
         foreach (shadow_words[i]) shadow_words[i] = '0;
         foreach (cmd_seen[i]) cmd_seen[i] = 0;
      endfunction

      function int unsigned pending();
         return awaited_replies.size();
      endfunction

      function int unsigned stored_words();
         return shadow_count;
      endfunction

      local function void queue_reply(input logic signed [WORD_W-1:0] data,
                                      input logic [1:0] status, input logic last);
         stack_reply_type r;
         r.data   = data;
         r.status = status;
         r.last   = last;
         awaited_replies.push_back(r);
         if (status == RSP_OVERFLOW) overflow_seen++;
         if (status == RSP_UNDER) under_seen++;
         if (status == RSP_EMPTY) empty_seen++;
      endfunction

      // called once per accepted command beat
      function void note_command(input logic [2:0] cmd,
                                 input logic signed [WORD_W-1:0] value,
                                 input logic [POS_W-1:0] position);
         bit          pos_ok;
         int unsigned slot;
         int unsigned k;
         pos_ok = (position != 0) && (position <= shadow_count);
         slot   = shadow_count - position;
         cmd_seen[cmd]++;
         case (cmd)
            CMD_PUSH: begin
               if (shadow_count == STACK_WORDS) begin
                  queue_reply('0, RSP_OVERFLOW, 1'b1);
               end else begin
                  shadow_words[shadow_count] = value;
                  shadow_count++;
                  queue_reply('0, RSP_OK, 1'b1);
               end
            end
            CMD_POP: begin
               if (shadow_count == 0) begin
                  queue_reply('0, RSP_UNDER, 1'b1);
               end else begin
                  shadow_count--;
                  queue_reply(shadow_words[shadow_count], RSP_OK, 1'b1);
               end
            end
            CMD_PEEP: begin
               if (pos_ok) queue_reply(shadow_words[slot], RSP_OK, 1'b1);
               else queue_reply('0, RSP_UNDER, 1'b1);
            end
            CMD_CHANGE: begin
               if (pos_ok) begin
                  shadow_words[slot] = value;
                  queue_reply('0, RSP_OK, 1'b1);
               end else begin
                  queue_reply('0, RSP_UNDER, 1'b1);
               end
            end
            CMD_DISPLAY: begin
               if (shadow_count == 0) begin
                  queue_reply('0, RSP_EMPTY, 1'b1);
               end else begin
                  for (k = shadow_count; k > 0; k--)
                     queue_reply(shadow_words[k-1], RSP_OK, k == 1);
               end
            end
            default: ;
         endcase
         if (shadow_count > deepest) deepest = shadow_count;
      endfunction

      function void check_reply(input logic signed [WORD_W-1:0] data,
                                input logic [1:0] status, input logic last);
         stack_reply_type want;
         replies_checked++;
         if (awaited_replies.size() == 0) begin
            $error("unexpected reply beat: data %0d status %0d last %0b", data, status, last);
            mismatches++;
            return;
         end
         want = awaited_replies.pop_front();
         if (data !== want.data) begin
            $error("rsp_data mismatch: expected %0d, actual %0d", want.data, data);
            mismatches++;
         end
         if (status !== want.status) begin
            $error("rsp_status mismatch: expected %0d, actual %0d", want.status, status);
            mismatches++;
         end
         if (last !== want.last) begin
            $error("rsp_last mismatch: expected %0b, actual %0b", want.last, last);
            mismatches++;
         end
      endfunction
   endclass

endpackage

// File: bench/array_stack_engine_test.sv
`timescale 1ns / 1ps
// array_stack_engine_test: self-checking bench for the array stack engine
// directed corner cases, then random phases of push, pop, peep, change and display
// depends on ase_pkg, stack_shadow_pkg and the array_stack_engine rtl
module array_stack_engine_test;
   import ase_pkg::*;
   import stack_shadow_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned PHASE_BEATS = 40;

   logic               clock        = 1'b0;
   logic               reset        = 1'b1;
   logic               start        = 1'b0;
   logic [2:0]         req_command  = CMD_PUSH;
   logic signed [31:0] req_value    = '0;
   logic [4:0]         req_position = '0;
   logic               busy;
   logic               rsp_valid;
   logic signed [31:0] rsp_data;
   logic [1:0]         rsp_status;
   logic               rsp_last;

   stack_shadow shadow;
   int unsigned cycle_count = 0;
   // chance in percent that the sender idles before a beat
   int unsigned idle_pct    = 16;

   always #4 clock = ~clock;

   array_stack_engine #(
      .STACK_DEPTH (STACK_WORDS)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_command  (req_command),
      .req_value    (req_value),
      .req_position (req_position),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last)
   );

   // monitor: all values are read at the edge, before the rtl's updates land
   // replies are checked before the new command is noted, so a reply can
   // never be matched against what the same edge's command predicts
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1) shadow.check_reply(rsp_data, rsp_status, rsp_last);
         if (start && busy === 1'b0) shadow.note_command(req_command, req_value, req_position);
      end
   end

   // hang guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL array_stack_engine");
         $finish;
      end
   end

   // idle with start low and junk on the request fields
   task automatic idle_cycle();
      start        <= 1'b0;
      req_command  <= 3'($urandom_range(7));
      req_value    <= $urandom;
      req_position <= 5'($urandom_range(31));
      @(posedge clock);
   endtask

   // present one command beat and hold it until the block takes it
   task automatic send_beat(input logic [2:0] cmd, input logic signed [31:0] value,
                            input logic [4:0] position);
      while ($urandom_range(99) < idle_pct) idle_cycle();
      start        <= 1'b1;
      req_command  <= cmd;
      req_value    <= value;
      req_position <= position;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   // sender holds off until every predicted reply has come back
   task automatic drain_replies();
      start <= 1'b0;
      @(posedge clock);
      while (shadow.pending() != 0) @(posedge clock);
   endtask

   // one random command; push_pct steers the stack toward full or empty
   task automatic send_random(input int unsigned push_pct, output bit counted);
      int unsigned        roll;
      int unsigned        depth_now;
      logic [2:0]         cmd;
      logic signed [31:0] value;
      logic [4:0]         position;
      roll = $urandom_range(99);
      if (roll < push_pct) begin
         cmd = CMD_PUSH;
      end else begin
         roll = $urandom_range(99);
         if (roll < 40) cmd = CMD_POP;
         else if (roll < 62) cmd = CMD_PEEP;
         else if (roll < 82) cmd = CMD_CHANGE;
         else if (roll < 96) cmd = CMD_DISPLAY;
         else cmd = 3'($urandom_range(7, 5));   // unused codes, dropped by the block
      end
      // words at the signed extremes show up often
      case ($urandom_range(9))
         0:       value = 32'sh7fffffff;
         1:       value = 32'sh80000000;
         2:       value = -32'sd1;
         3:       value = '0;
         default: value = $urandom;
      endcase
      // mostly positions that hit a stored word, some just past the bottom,
      // some zero and some anywhere in the field's range
      depth_now = shadow.stored_words();
      case ($urandom_range(9))
         0:       position = '0;
         1:       position = 5'($urandom_range(31));
         2:       position = 5'(depth_now + 1);
         default: position = (depth_now == 0) ? 5'($urandom_range(1, 3))
                                              : 5'($urandom_range(1, depth_now));
      endcase
      counted = (cmd <= CMD_DISPLAY);
      send_beat(cmd, value, position);
   endtask

   // a run of random commands with one push mix, then a wait for every pending reply
   task automatic run_phase(input int unsigned push_pct, input int unsigned idle_chance);
      int unsigned beats;
      bit          counted;
      beats    = 0;
      idle_pct = idle_chance;
      while (beats < PHASE_BEATS) begin
         send_random(push_pct, counted);
         if (counted) beats++;
      end
      drain_replies();
   endtask

   initial begin
      shadow = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty stack: every pop, peep, change and display must refuse
      send_beat(CMD_POP, '0, 5'd0);
      send_beat(CMD_PEEP, '0, 5'd1);
      send_beat(CMD_CHANGE, 32'sd9, 5'd1);
      send_beat(CMD_DISPLAY, '0, 5'd0);
      // unused codes give nothing back
      send_beat(3'd5, 32'sd1, 5'd1);
      send_beat(3'd6, 32'sd2, 5'd2);
      send_beat(3'd7, 32'sd3, 5'd3);
      // signed extremes in the store
      send_beat(CMD_PUSH, 32'sh7fffffff, 5'd0);
      send_beat(CMD_PUSH, 32'sh80000000, 5'd0);
      send_beat(CMD_PUSH, -32'sd1, 5'd0);
      send_beat(CMD_PUSH, 32'sd9, 5'd0);
      // position zero, top, bottom, one past bottom, far out of range
      send_beat(CMD_PEEP, '0, 5'd0);
      send_beat(CMD_PEEP, '0, 5'd1);
      send_beat(CMD_PEEP, '0, 5'd4);
      send_beat(CMD_PEEP, '0, 5'd5);
      send_beat(CMD_PEEP, '0, 5'd31);
      send_beat(CMD_CHANGE, 32'sh5a5a5a5a, 5'd2);
      send_beat(CMD_CHANGE, 32'sd1, 5'd0);
      send_beat(CMD_CHANGE, 32'sd1, 5'd5);
      // display walks top to bottom, then a push lands right behind it
      send_beat(CMD_DISPLAY, '0, 5'd0);
      send_beat(CMD_PUSH, 32'sd16, 5'd0);
      send_beat(CMD_POP, '0, 5'd0);
      send_beat(CMD_POP, '0, 5'd0);
      drain_replies();

      // fill to overflow, mixed, drain to underflow, a stretch with no idling, mixed
      run_phase(60, 16);
      run_phase(35, 16);
      run_phase(15, 16);
      run_phase(45, 0);
      run_phase(35, 16);

      // nothing outstanding now; give a stray beat time to show up
      repeat (20) @(posedge clock);

      $display("covered %0d push, %0d pop, %0d peep, %0d change, %0d display, %0d unused beats",
               shadow.cmd_seen[CMD_PUSH], shadow.cmd_seen[CMD_POP],
               shadow.cmd_seen[CMD_PEEP], shadow.cmd_seen[CMD_CHANGE],
               shadow.cmd_seen[CMD_DISPLAY],
               shadow.cmd_seen[5] + shadow.cmd_seen[6] + shadow.cmd_seen[7]);
      $display("%0d replies checked: %0d overflow, %0d underflow or bad position, %0d empty",
               shadow.replies_checked, shadow.overflow_seen, shadow.under_seen,
               shadow.empty_seen);
      $display("deepest stack %0d", shadow.deepest);
      if (shadow.mismatches == 0) begin
         $display("PASS array_stack_engine");
      end else begin
         $display("FAIL array_stack_engine");
      end
      $finish;
   end

endmodule
